// ===== rtl/ambient_light_lux_converter_top_macros.svh =====
// assertion helpers for the lux converter
`ifndef AMBIENT_LIGHT_LUX_CONVERTER_TOP_MACROS_SVH
`define AMBIENT_LIGHT_LUX_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ALC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ALC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/alc_pkg.sv =====
`timescale 1ns / 1ps

package alc_pkg;

    // field and datapath widths
    localparam int COUNT_W   = 16;
    localparam int GAIN_W    = 2;
    localparam int ITIME_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int LUX_W     = 56;
    localparam int SCALED_W  = 23;  // counts * 84
    localparam int NUM_W     = 27;  // counts * gain multiplier * 84
    localparam int NUMER_W   = 43;  // dividend, num << 16 at most
    localparam int DEN_LIN_W = 15;  // 25 * time
    localparam int DEN_W     = 25;  // 25000 * time
    localparam int QUOT_W    = 28;  // quotient bits, one divider stage each
    localparam int K2_W      = 40;
    localparam int K3_W      = 52;
    localparam int K4_W      = 64;
    localparam int TERM_W    = 64;

    localparam int FRAC_BITS_DEF = 8;
    localparam int KQ_SHIFT      = 16;  // kilolux kept in q16
    localparam int COEF_Q        = 48;  // coefficient q32 plus kilolux q16

    localparam int COUNT_SCALE   = 84;
    localparam int LIN_SCALE     = 25;
    localparam int CORR_SCALE    = 25000;
    localparam int ITIME_DEFAULT = 100;
    localparam int LIN_LIMIT     = 1000;

    // pipeline timing
    localparam int MUL_LAT   = 2;
    localparam int FRONT_LAT = 2;
    localparam int POLY_LAT  = 4 * MUL_LAT + 3;
    localparam int PIPE_LAT  = FRONT_LAT + QUOT_W + POLY_LAT;

    // correction coefficients, q32
    localparam int COEF_B1_W = 42;
    localparam int COEF_B2_W = 39;
    localparam int COEF_B3_W = 36;
    localparam int COEF_B4_W = 32;
    localparam logic [COEF_B1_W-1:0] COEF_B1 = 42'd4304845720781;
    localparam logic [COEF_B2_W-1:0] COEF_B2 = 39'd349988295016;
    localparam logic [COEF_B3_W-1:0] COEF_B3 = 36'd40340050831;
    localparam logic [COEF_B4_W-1:0] COEF_B4 = 32'd2582778583;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITIME = 2'd1;

    typedef enum logic [GAIN_W-1:0] {
        GAIN_X1   = 2'd0,
        GAIN_X2   = 2'd1,
        GAIN_X1_8 = 2'd2,
        GAIN_X1_4 = 2'd3
    } gain_t;

    // log2 of the gain multiplier 2 / gain
    function automatic logic [2:0] gain_shift(gain_t g);
        logic [2:0] sh;
        unique case (g)
            GAIN_X1:   sh = 3'd1;
            GAIN_X2:   sh = 3'd0;
            GAIN_X1_8: sh = 3'd4;
            GAIN_X1_4: sh = 3'd3;
        endcase
        return sh;
    endfunction

    typedef struct packed {
        logic [NUMER_W-1:0] numer;
        logic [DEN_W-1:0]   den;
        logic               corr;
    } div_in_t;

    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [QUOT_W-1:0] nq;
        logic [DEN_W-1:0]  den;
        logic              corr;
    } div_stage_t;

endpackage

// ===== rtl/alc_delay.sv =====
`timescale 1ns / 1ps

module alc_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] shift_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            shift_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                shift_reg[i] <= shift_reg[i-1];
            end
        end
    end

    assign dout = shift_reg[DEPTH-1];

endmodule

// ===== rtl/alc_mul.sv =====
`timescale 1ns / 1ps

// two-stage multiplier: b split in halves, partials registered, then summed
module alc_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 16,
    parameter int OW = 32
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic [OW-1:0] p
);

    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AW+BL-1:0] plo_reg;
    logic [AW+BH-1:0] phi_reg;
    logic [PW-1:0]    sum;
    logic [OW-1:0]    p_reg;
    logic [OW-1:0]    p_next;

    always_comb begin
        sum    = PW'(plo_reg) + (PW'(phi_reg) << BL);
        p_next = OW'(sum >> SH);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg <= a * b[BL-1:0];
            phi_reg <= a * b[BW-1:BL];
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/alc_front.sv =====
`timescale 1ns / 1ps

// scales the count and picks dividend and divisor for the linear or kilolux path
module alc_front import alc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [COUNT_W-1:0]   counts,
    input  gain_t                gain,
    input  logic [DEN_LIN_W-1:0] den_lin,
    input  logic [DEN_W-1:0]     den_corr,
    output div_in_t              dout
);

    logic [SCALED_W-1:0] scaled_reg;
    logic [SCALED_W-1:0] scaled_next;
    logic [NUM_W-1:0]    num;
    div_in_t             dout_reg;
    div_in_t             dout_next;

    always_comb begin
        scaled_next = SCALED_W'(counts * COUNT_SCALE);
        num         = NUM_W'(scaled_reg) << gain_shift(gain);
        // above 1000 lux: divide by 25000*T into kilolux q16
        dout_next.corr = num > NUM_W'(den_corr);
        if (dout_next.corr) begin
            dout_next.numer = NUMER_W'(num) << KQ_SHIFT;
            dout_next.den   = den_corr;
        end else begin
            dout_next.numer = NUMER_W'(num) << FRAC_BITS;
            dout_next.den   = DEN_W'(den_lin);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scaled_reg <= scaled_next;
            dout_reg   <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/alc_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage
module alc_div import alc_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  div_in_t           din,
    output logic [QUOT_W-1:0] quot,
    output logic              corr
);

    div_stage_t st_in   [QUOT_W];
    div_stage_t st_next [QUOT_W];
    div_stage_t st_reg  [QUOT_W];

    assign st_in[0] = '{rem:  DEN_W'(din.numer[NUMER_W-1:QUOT_W]),
                        nq:   din.numer[QUOT_W-1:0],
                        den:  din.den,
                        corr: din.corr};

    for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        if (i > 0) begin : g_link
            assign st_in[i] = st_reg[i-1];
        end

        always_comb begin
            trial = {st_in[i].rem, st_in[i].nq[QUOT_W-1]};
            diff  = trial - {1'b0, st_in[i].den};
            ge    = trial >= {1'b0, st_in[i].den};
            st_next[i].rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            st_next[i].nq   = {st_in[i].nq[QUOT_W-2:0], ge};
            st_next[i].den  = st_in[i].den;
            st_next[i].corr = st_in[i].corr;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign quot = st_reg[QUOT_W-1].nq;
    assign corr = st_reg[QUOT_W-1].corr;

endmodule

// ===== rtl/alc_poly.sv =====
`timescale 1ns / 1ps

// quartic correction b4*k^4 - b3*k^3 + b2*k^2 + b1*k on kilolux q16
module alc_poly import alc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [QUOT_W-1:0] k,
    output logic [LUX_W-1:0]  lux
);

    localparam int SH    = COEF_Q - FRAC_BITS;
    localparam int SUM_W = TERM_W + 2;

    logic [QUOT_W-1:0] k_d1;
    logic [QUOT_W-1:0] k_d2;
    logic [K2_W-1:0]   k2;
    logic [K3_W-1:0]   k3;
    logic [K4_W-1:0]   k4;
    logic [TERM_W-1:0] t1;
    logic [TERM_W-1:0] t2;
    logic [TERM_W-1:0] t3;
    logic [TERM_W-1:0] t4;
    logic [TERM_W-1:0] t1_d;
    logic [TERM_W-1:0] t2_d;
    logic [TERM_W-1:0] t3_d;

    logic [SUM_W-1:0]  s1_reg;
    logic [SUM_W-1:0]  s1_next;
    logic [SUM_W-1:0]  s2_reg;
    logic [SUM_W-1:0]  s2_next;
    logic [SUM_W-1:0]  diff;
    logic [LUX_W-1:0]  lux_reg;
    logic [LUX_W-1:0]  lux_next;

    // powers of k
    alc_mul #(.AW(QUOT_W), .BW(QUOT_W), .SH(KQ_SHIFT), .OW(K2_W)) u_k2 (
        .aclk(aclk), .en(en), .a(k), .b(k), .p(k2)
    );
    alc_delay #(.W(QUOT_W), .DEPTH(MUL_LAT)) u_kd1 (
        .aclk(aclk), .en(en), .din(k), .dout(k_d1)
    );
    alc_mul #(.AW(K2_W), .BW(QUOT_W), .SH(KQ_SHIFT), .OW(K3_W)) u_k3 (
        .aclk(aclk), .en(en), .a(k2), .b(k_d1), .p(k3)
    );
    alc_delay #(.W(QUOT_W), .DEPTH(2 * MUL_LAT)) u_kd2 (
        .aclk(aclk), .en(en), .din(k), .dout(k_d2)
    );
    alc_mul #(.AW(K3_W), .BW(QUOT_W), .SH(KQ_SHIFT), .OW(K4_W)) u_k4 (
        .aclk(aclk), .en(en), .a(k3), .b(k_d2), .p(k4)
    );

    // coefficient terms
    alc_mul #(.AW(COEF_B1_W), .BW(QUOT_W), .SH(SH), .OW(TERM_W)) u_t1 (
        .aclk(aclk), .en(en), .a(COEF_B1), .b(k), .p(t1)
    );
    alc_mul #(.AW(COEF_B2_W), .BW(K2_W), .SH(SH), .OW(TERM_W)) u_t2 (
        .aclk(aclk), .en(en), .a(COEF_B2), .b(k2), .p(t2)
    );
    alc_mul #(.AW(COEF_B3_W), .BW(K3_W), .SH(SH), .OW(TERM_W)) u_t3 (
        .aclk(aclk), .en(en), .a(COEF_B3), .b(k3), .p(t3)
    );
    alc_mul #(.AW(COEF_B4_W), .BW(K4_W), .SH(SH), .OW(TERM_W)) u_t4 (
        .aclk(aclk), .en(en), .a(COEF_B4), .b(k4), .p(t4)
    );

    // align the early terms with the adder stages
    alc_delay #(.W(TERM_W), .DEPTH(3 * MUL_LAT)) u_t1d (
        .aclk(aclk), .en(en), .din(t1), .dout(t1_d)
    );
    alc_delay #(.W(TERM_W), .DEPTH(2 * MUL_LAT + 1)) u_t2d (
        .aclk(aclk), .en(en), .din(t2), .dout(t2_d)
    );
    alc_delay #(.W(TERM_W), .DEPTH(MUL_LAT + 2)) u_t3d (
        .aclk(aclk), .en(en), .din(t3), .dout(t3_d)
    );

    always_comb begin
        s1_next = SUM_W'(t4) + SUM_W'(t1_d);
        s2_next = s1_reg + SUM_W'(t2_d);
        diff    = s2_reg - SUM_W'(t3_d);
        if (s2_reg <= SUM_W'(t3_d)) begin
            lux_next = '0;
        end else if (diff > SUM_W'({LUX_W{1'b1}})) begin
            lux_next = {LUX_W{1'b1}};
        end else begin
            lux_next = diff[LUX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            lux_reg <= lux_next;
        end
    end

    assign lux = lux_reg;

endmodule

// ===== rtl/ambient_light_lux_converter_top.sv =====
// throughput: one word per cycle while the skid stage is empty; the 28-stage divider and
//   the 11-stage correction pipeline both advance every cycle while the skid stage is empty
// reset: synchronous active-low aresetn clears all valid bits and loads gain x1, 100 ms
`timescale 1ns / 1ps
`include "ambient_light_lux_converter_top_macros.svh"

module ambient_light_lux_converter_top import alc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ITIME_W-1:0]   cfg_data,

    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [COUNT_W-1:0]   s_tdata,   // [15:0] counts

    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [LUX_W-1:0]     m_tdata,   // [55:0] lux_q8
    output logic                 m_tuser    // [0] corrected
);

    // ---------------------------------------------------------------
    // configuration: divisors are derived at write time so that an
    // item arriving right after a write sees them
    // ---------------------------------------------------------------
    gain_t                gain_reg;
    gain_t                gain_next;
    logic [DEN_LIN_W-1:0] den_lin_reg;
    logic [DEN_LIN_W-1:0] den_lin_next;
    logic [DEN_W-1:0]     den_corr_reg;
    logic [DEN_W-1:0]     den_corr_next;
    logic [ITIME_W-1:0]   time_eff;

    // no write is taken while reset is held
    assign cfg_ready = aresetn;

    always_comb begin
        gain_next     = gain_reg;
        den_lin_next  = den_lin_reg;
        den_corr_next = den_corr_reg;
        // zero integration time means the default
        time_eff = (cfg_data == '0) ? ITIME_W'(ITIME_DEFAULT) : cfg_data;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_GAIN: begin
                    gain_next = gain_t'(cfg_data[GAIN_W-1:0]);
                end
                REG_ITIME: begin
                    den_lin_next  = DEN_LIN_W'(time_eff * LIN_SCALE);
                    den_corr_next = DEN_W'(time_eff * CORR_SCALE);
                end
                default: begin
                    // unmapped index, write ignored
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_X1;
            den_lin_reg  <= DEN_LIN_W'(LIN_SCALE * ITIME_DEFAULT);
            den_corr_reg <= DEN_W'(CORR_SCALE * ITIME_DEFAULT);
        end else begin
            gain_reg     <= gain_next;
            den_lin_reg  <= den_lin_next;
            den_corr_reg <= den_corr_next;
        end
    end

    // ---------------------------------------------------------------
    // pipeline control: everything moves together while the skid
    // stage is empty, valid bits ride alongside the data
    // ---------------------------------------------------------------
    logic                pipe_en;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;
    logic                pipe_valid;

    // input closed while reset is held
    assign s_tready   = pipe_en && aresetn;
    assign pipe_valid = vld_reg[PIPE_LAT-1];

    always_comb begin
        vld_next = vld_reg;
        if (pipe_en) begin
            vld_next = {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------
    // datapath: scale, divide, correct
    // ---------------------------------------------------------------
    div_in_t            div_in;
    logic [QUOT_W-1:0]  quot;
    logic               quot_corr;
    logic [LUX_W-1:0]   lux_poly;
    logic [QUOT_W:0]    lin_d;     // {corr flag, linear quotient}
    logic [LUX_W-1:0]   res_lux;
    logic               res_corr;

    alc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk     (aclk),
        .en       (pipe_en),
        .counts   (s_tdata),
        .gain     (gain_reg),
        .den_lin  (den_lin_reg),
        .den_corr (den_corr_reg),
        .dout     (div_in)
    );

    // one divider serves both paths: lux q(FRAC_BITS) or kilolux q16
    alc_div u_div (
        .aclk (aclk),
        .en   (pipe_en),
        .din  (div_in),
        .quot (quot),
        .corr (quot_corr)
    );

    alc_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
        .aclk (aclk),
        .en   (pipe_en),
        .k    (quot),
        .lux  (lux_poly)
    );

    // linear result waits for the correction pipeline
    alc_delay #(.W(QUOT_W + 1), .DEPTH(POLY_LAT)) u_lin_dly (
        .aclk (aclk),
        .en   (pipe_en),
        .din  ({quot_corr, quot}),
        .dout (lin_d)
    );

    assign res_corr = lin_d[QUOT_W];
    assign res_lux  = res_corr ? lux_poly : LUX_W'(lin_d[QUOT_W-1:0]);

    // ---------------------------------------------------------------
    // output register plus skid word: a result that meets a stalled
    // output parks in the skid word and freezes the pipeline
    // ---------------------------------------------------------------
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [LUX_W-1:0] out_lux_reg;
    logic [LUX_W-1:0] out_lux_next;
    logic             out_corr_reg;
    logic             out_corr_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [LUX_W-1:0] skid_lux_reg;
    logic [LUX_W-1:0] skid_lux_next;
    logic             skid_corr_reg;
    logic             skid_corr_next;
    logic             out_take;

    assign pipe_en  = !skid_valid_reg;
    assign out_take = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_lux_next    = out_lux_reg;
        out_corr_next   = out_corr_reg;
        skid_valid_next = skid_valid_reg;
        skid_lux_next   = skid_lux_reg;
        skid_corr_next  = skid_corr_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_lux_next    = skid_lux_reg;
                out_corr_next   = skid_corr_reg;
                skid_valid_next = 1'b0;
            end
        end else if (pipe_valid) begin
            if (!out_valid_reg || out_take) begin
                out_valid_next = 1'b1;
                out_lux_next   = res_lux;
                out_corr_next  = res_corr;
            end else begin
                skid_valid_next = 1'b1;
                skid_lux_next   = res_lux;
                skid_corr_next  = res_corr;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_lux_reg   <= out_lux_next;
        out_corr_reg  <= out_corr_next;
        skid_lux_reg  <= skid_lux_next;
        skid_corr_reg <= skid_corr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_lux_reg;
    assign m_tuser  = out_corr_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // the skid word only fills behind a held output word
    `ALC_ASSERT_IMPLY(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid word without output word")
    // a frozen pipeline keeps its valid bits
    `ALC_ASSERT_NEXT(a_frozen_holds, aclk, aresetn, !pipe_en, $stable(vld_reg), "valid bits moved while frozen")
    // an accepted word enters the first stage
    `ALC_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, vld_reg[0], "accepted word lost at entry")
    // an uncorrected result never exceeds the threshold
    `ALC_ASSERT_IMPLY(a_linear_range, aclk, aresetn, m_tvalid && !m_tuser, m_tdata <= (LUX_W'(LIN_LIMIT) << FRAC_BITS), "linear lux above threshold")

endmodule
